// ===== hw/rtl/u2r_pkg.sv =====
// Shared constants, types and coefficient quantization for the UYVY to RGB24 converter.
// Used by uyvy_to_rgb24_converter_core and u2r_pixel_finish; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package u2r_pkg;

    // Default number of fraction bits in the color weights
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Real weights are given in units of 1e-7
    localparam longint COEF_SCALE_DEN = 64'sd10000000;

    localparam longint COEF_RU_E7 = 64'sd9267;      // red from U, negated
    localparam longint COEF_RV_E7 = 64'sd14016868;  // red from V
    localparam longint COEF_GU_E7 = 64'sd3436954;   // green from U, negated
    localparam longint COEF_GV_E7 = 64'sd7141690;   // green from V, negated
    localparam longint COEF_BU_E7 = 64'sd17721604;  // blue from U
    localparam longint COEF_BV_E7 = 64'sd9902;      // blue from V

    localparam int CHAN_W = 8;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef logic [CHAN_W-1:0] chan_t;

    // Load enables of the two back stages of one pixel lane
    typedef struct packed {
        logic load_sum;
        logic load_out;
    } lane_ctrl_t;

    // Round half up of c * 2^frac, evaluated at elaboration
    function automatic longint quant_coef(input longint c_e7, input int frac);
        longint scaled;
        scaled = c_e7 * (64'sd1 <<< frac);
        return (scaled + COEF_SCALE_DEN / 2) / COEF_SCALE_DEN;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u2r_pixel_finish.sv =====
// Sum and saturation stages of one RGB pixel lane.
// Depends on u2r_pkg for the channel type and lane control struct.
`timescale 1ns / 1ps
`default_nettype none

module u2r_pixel_finish #(
    parameter int COEF_FRAC_BITS = u2r_pkg::COEF_FRAC_BITS_DEF,
    parameter int PROD_W         = COEF_FRAC_BITS + 11
) (
    input  wire logic                     clk,
    input  wire u2r_pkg::lane_ctrl_t      ctrl,
    input  wire logic [7:0]               luma,
    input  wire logic signed [PROD_W-1:0] red_u,
    input  wire logic signed [PROD_W-1:0] red_v,
    input  wire logic signed [PROD_W-1:0] green_u,
    input  wire logic signed [PROD_W-1:0] green_v,
    input  wire logic signed [PROD_W-1:0] blue_u,
    input  wire logic signed [PROD_W-1:0] blue_v,
    output u2r_pkg::chan_t                red,
    output u2r_pkg::chan_t                green,
    output u2r_pkg::chan_t                blue
);

    localparam int ACC_W = COEF_FRAC_BITS + 12;

    logic signed [ACC_W-1:0] luma_ext;
    logic signed [ACC_W-1:0] red_acc_reg, green_acc_reg, blue_acc_reg;
    logic signed [ACC_W-1:0] red_acc_next, green_acc_next, blue_acc_next;
    u2r_pkg::chan_t          red_reg, green_reg, blue_reg;
    u2r_pkg::chan_t          red_next, green_next, blue_next;

    // Clamp a fixed-point sum to 0..255 after dropping the fraction
    function automatic u2r_pkg::chan_t sat_chan(input logic signed [ACC_W-1:0] acc);
        u2r_pkg::chan_t res;
        if (acc[ACC_W-1])
            res = '0;
        else if (|acc[ACC_W-2:COEF_FRAC_BITS+8])
            res = u2r_pkg::CHAN_MAX;
        else
            res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        return res;
    endfunction

    assign luma_ext = ACC_W'($signed({1'b0, luma, {COEF_FRAC_BITS{1'b0}}}));

    always_comb
    begin
        red_acc_next   = luma_ext + ACC_W'(red_u)   + ACC_W'(red_v);
        green_acc_next = luma_ext + ACC_W'(green_u) + ACC_W'(green_v);
        blue_acc_next  = luma_ext + ACC_W'(blue_u)  + ACC_W'(blue_v);
        red_next       = sat_chan(red_acc_reg);
        green_next     = sat_chan(green_acc_reg);
        blue_next      = sat_chan(blue_acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            red_acc_reg   <= red_acc_next;
            green_acc_reg <= green_acc_next;
            blue_acc_reg  <= blue_acc_next;
        end
        if (ctrl.load_out)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/uyvy_to_rgb24_converter_core.sv =====
// Top level of the UYVY 4:2:2 to RGB24 converter: stream ports, pipeline control, chroma products.
// Depends on u2r_pkg and u2r_pixel_finish.
`timescale 1ns / 1ps
`default_nettype none

// Converts one UYVY macropixel per transfer into two RGB24 pixels that share
// the chroma pair. Each channel is Y plus a signed fixed-point weighted sum of
// U-128 and V-128, floored and clamped to 0..255; the weights carry
// COEF_FRAC_BITS fraction bits and are fixed at elaboration. tlast marks the
// last macropixel of a frame and passes through with its pixels. The block
// takes one macropixel every clock and delivers one result every clock while
// the master side does not stall; a transfer passes through the four register
// stages in order: input capture, chroma products, sums, clamp. Each stage
// holds its own valid bit and advances whenever the stage ahead of it is
// empty or moving, so bubbles collapse and a stall on the master side backs
// up without losing or repeating a transfer. The block keeps no state between
// macropixels; reset only clears the valid bits.
module uyvy_to_rgb24_converter_core #(
    parameter int COEF_FRAC_BITS = u2r_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cb_sample[7:0], luma_first[15:8], cr_sample[23:16], luma_second[31:24]
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,   // frame_end_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // red_first[7:0], green_first[15:8], blue_first[23:16],
    // red_second[31:24], green_second[39:32], blue_second[47:40]
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast    // frame_end_out
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int DIFF_W = 9;
    localparam int PROD_W = COEF_W + DIFF_W;

    // Weights, rounded half up at elaboration
    localparam logic signed [COEF_W-1:0] K_RU =
        COEF_W'(-u2r_pkg::quant_coef(u2r_pkg::COEF_RU_E7, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] K_RV =
        COEF_W'(u2r_pkg::quant_coef(u2r_pkg::COEF_RV_E7, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] K_GU =
        COEF_W'(-u2r_pkg::quant_coef(u2r_pkg::COEF_GU_E7, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] K_GV =
        COEF_W'(-u2r_pkg::quant_coef(u2r_pkg::COEF_GV_E7, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] K_BU =
        COEF_W'(u2r_pkg::quant_coef(u2r_pkg::COEF_BU_E7, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] K_BV =
        COEF_W'(u2r_pkg::quant_coef(u2r_pkg::COEF_BV_E7, COEF_FRAC_BITS));

    // Stage valid bits and per-stage advance conditions
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    // Stage 0: captured macropixel, chroma already offset by -128
    logic signed [DIFF_W-1:0] du_reg, dv_reg, du_next, dv_next;
    logic [7:0]               y1_s0_reg, y2_s0_reg;
    logic                     last_s0_reg;

    // Stage 1: chroma products shared by both pixels
    logic signed [PROD_W-1:0] ru_reg, rv_reg, gu_reg, gv_reg, bu_reg, bv_reg;
    logic signed [PROD_W-1:0] ru_next, rv_next, gu_next, gv_next, bu_next, bv_next;
    logic [7:0]               y1_s1_reg, y2_s1_reg;
    logic                     last_s1_reg;

    // Stages 2 and 3 hold tlast here; the pixel lanes hold the channels
    logic                     last_s2_reg, last_s3_reg;

    u2r_pkg::lane_ctrl_t      lane_ctrl;
    u2r_pkg::chan_t           r1, g1, b1, r2, g2, b2;

    // A stage may take new data when it is empty or its content moves on
    always_comb
    begin
        rdy3 = !v3_reg || m_axis_tready;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        rdy0 = !v0_reg || rdy1;
    end

    assign s_axis_tready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= s_axis_tvalid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // U - 128 on a byte is the top bit flipped, read as signed
    always_comb
    begin
        du_next = DIFF_W'($signed({~s_axis_tdata[7],  s_axis_tdata[6:0]}));
        dv_next = DIFF_W'($signed({~s_axis_tdata[23], s_axis_tdata[22:16]}));
        ru_next = PROD_W'(K_RU) * PROD_W'(du_reg);
        rv_next = PROD_W'(K_RV) * PROD_W'(dv_reg);
        gu_next = PROD_W'(K_GU) * PROD_W'(du_reg);
        gv_next = PROD_W'(K_GV) * PROD_W'(dv_reg);
        bu_next = PROD_W'(K_BU) * PROD_W'(du_reg);
        bv_next = PROD_W'(K_BV) * PROD_W'(dv_reg);
    end

    // Payload loads only when valid data arrives; no reset needed
    always_ff @(posedge clk)
    begin
        if (rdy0 && s_axis_tvalid)
        begin
            du_reg      <= du_next;
            dv_reg      <= dv_next;
            y1_s0_reg   <= s_axis_tdata[15:8];
            y2_s0_reg   <= s_axis_tdata[31:24];
            last_s0_reg <= s_axis_tlast;
        end
        if (rdy1 && v0_reg)
        begin
            ru_reg      <= ru_next;
            rv_reg      <= rv_next;
            gu_reg      <= gu_next;
            gv_reg      <= gv_next;
            bu_reg      <= bu_next;
            bv_reg      <= bv_next;
            y1_s1_reg   <= y1_s0_reg;
            y2_s1_reg   <= y2_s0_reg;
            last_s1_reg <= last_s0_reg;
        end
        if (lane_ctrl.load_sum)
            last_s2_reg <= last_s1_reg;
        if (lane_ctrl.load_out)
            last_s3_reg <= last_s2_reg;
    end

    always_comb
    begin
        lane_ctrl.load_sum = rdy2 && v1_reg;
        lane_ctrl.load_out = rdy3 && v2_reg;
    end

    u2r_pixel_finish #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .PROD_W         (PROD_W)
    ) u_lane_first (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .luma    (y1_s1_reg),
        .red_u   (ru_reg),
        .red_v   (rv_reg),
        .green_u (gu_reg),
        .green_v (gv_reg),
        .blue_u  (bu_reg),
        .blue_v  (bv_reg),
        .red     (r1),
        .green   (g1),
        .blue    (b1)
    );

    u2r_pixel_finish #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .PROD_W         (PROD_W)
    ) u_lane_second (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .luma    (y2_s1_reg),
        .red_u   (ru_reg),
        .red_v   (rv_reg),
        .green_u (gu_reg),
        .green_v (gv_reg),
        .blue_u  (bu_reg),
        .blue_v  (bv_reg),
        .red     (r2),
        .green   (g2),
        .blue    (b2)
    );

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {b2, g2, r2, b1, g1, r1};
    assign m_axis_tlast  = last_s3_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/u2r_checker.sv =====
// Port-level checker for the UYVY to RGB24 converter, bound to the top level.
// Depends on uyvy_to_rgb24_converter_core only through the bind at the end.
`timescale 1ns / 1ps
`default_nettype none

module u2r_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    logic s_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // Hold a stalled result
    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A free master side never throttles the slave side
    a_no_false_stall: assert property (@(posedge clk)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

    // Without back pressure an accepted transfer comes out once it has passed every stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
            |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind uyvy_to_rgb24_converter_core u2r_checker u_u2r_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
